// ===== src/assert_macros.svh =====
// assert_macros.svh: concurrent assertion helpers for the priority queue
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// invariant checked at every edge outside reset
`define SPQ_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked at every edge outside reset
`define SPQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== src/spq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants of the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int ValueBits       = 32;
	localparam int ReqPrioBits     = 8;
	localparam int DefQueueDepth   = 16;
	localparam int DefPriorityBits = 8;

	typedef enum logic {
		REQ_INSERT = 1'b0,
		REQ_REMOVE = 1'b1
	} req_t;

	typedef enum logic [1:0] {
		ST_INSERTED = 2'd0,
		ST_REMOVED  = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef struct packed {
		logic ins;
		logic rem;
	} cell_cmd_t;

endpackage

// ===== src/spq_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds an entry, keeps it, takes the new
// entry, or takes its neighbor's entry on insert and remove.
// ----------------------------------------------------------------------------
module spq_cell #(
	parameter int PRIO_BITS = spq_pkg::DefPriorityBits
) (
	input  logic                          clk,
	input  spq_pkg::cell_cmd_t            cmd,
	input  logic                          occupied,
	input  logic [spq_pkg::ValueBits-1:0] new_value,
	input  logic [PRIO_BITS-1:0]          new_prio,
	input  logic                          left_keep,
	input  logic [spq_pkg::ValueBits-1:0] left_value,
	input  logic [PRIO_BITS-1:0]          left_prio,
	input  logic [spq_pkg::ValueBits-1:0] right_value,
	input  logic [PRIO_BITS-1:0]          right_prio,
	output logic [spq_pkg::ValueBits-1:0] value,
	output logic [PRIO_BITS-1:0]          prio,
	output logic                          keep
);

	logic [spq_pkg::ValueBits-1:0] value_q;
	logic [PRIO_BITS-1:0]          prio_q;

	// entries at or above the new priority stay ahead of it
	assign keep  = occupied && (prio_q >= new_prio);
	assign value = value_q;
	assign prio  = prio_q;

	always_ff @(posedge clk) begin
		if (cmd.ins && !keep) begin
			if (left_keep) begin
				value_q <= new_value;
				prio_q  <= new_prio;
			end else begin
				value_q <= left_value;
				prio_q  <= left_prio;
			end
		end else if (cmd.rem) begin
			value_q <= right_value;
			prio_q  <= right_prio;
		end
	end

endmodule

// ===== src/sorted_priority_queue_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_top
// Bounded priority queue built as a chain of compare-and-shift cells.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_axis group: s_axis_tuser selects insert or
//   remove, s_axis_tdata carries the data word and its priority. Each
//   request word gives exactly one result word on m_axis: tuser holds the
//   status, tdata the removed data word and priority (zero otherwise).
//   Cell 0 holds the highest priority, oldest first among equals; an
//   insert shifts the lower entries one cell down, a remove shifts the
//   chain one cell up, both in the cycle the request is taken.
//   The result is registered and appears on m_axis in the cycle after acceptance.
//   Throughput: one request per cycle while the output register is empty or m_axis_tready
//   is high, set by the cell update and the one-deep output register.
//   A stalled receiver holds the result; s_axis_tready is low only while
//   the output register is full and m_axis_tready is low.
//   Reset empties the queue and the output register; slot contents are
//   not cleared, since only occupied cells are ever read.
// ----------------------------------------------------------------------------
module sorted_priority_queue_top #(
	parameter int QUEUE_DEPTH   = spq_pkg::DefQueueDepth,
	parameter int PRIORITY_BITS = spq_pkg::DefPriorityBits
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // [31:0] item_value, [39:32] priority_req
	input  logic        s_axis_tuser,  // [0] req_type
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // [31:0] out_value, [39:32] out_priority
	output logic [1:0]  m_axis_tuser   // [1:0] status
);

	localparam int VB = spq_pkg::ValueBits;
	localparam int RB = spq_pkg::ReqPrioBits;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic                      in_fire;
	logic                      is_remove;
	logic                      full;
	logic                      empty;
	logic [VB-1:0]             in_value;
	logic [PRIORITY_BITS+RB-1:0] pri_ext;
	logic [PRIORITY_BITS-1:0]  in_prio;
	logic [RB+PRIORITY_BITS-1:0] opri_ext;
	spq_pkg::cell_cmd_t        cmd;
	spq_pkg::status_t          status_d;
	logic [CW-1:0]             count_q;
	logic                      out_valid_q;
	spq_pkg::status_t          out_status_q;
	logic [VB-1:0]             out_value_q;
	logic [RB-1:0]             out_prio_q;

	logic [VB-1:0]             cell_value [QUEUE_DEPTH];
	logic [PRIORITY_BITS-1:0]  cell_prio  [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0]    cell_keep;

	assign in_fire   = s_axis_tvalid && s_axis_tready;
	assign is_remove = (spq_pkg::req_t'(s_axis_tuser) == spq_pkg::REQ_REMOVE);
	assign in_value  = s_axis_tdata[VB-1:0];
	assign pri_ext   = {{PRIORITY_BITS{1'b0}}, s_axis_tdata[VB+RB-1:VB]};
	assign in_prio   = pri_ext[PRIORITY_BITS-1:0];
	assign opri_ext  = {{RB{1'b0}}, cell_prio[0]};
	assign full      = (count_q == CW'(QUEUE_DEPTH));
	assign empty     = (count_q == '0);

	assign s_axis_tready = !out_valid_q || m_axis_tready;

	always_comb begin
		cmd.ins = in_fire && !is_remove && !full;
		cmd.rem = in_fire && is_remove && !empty;
		if (is_remove) begin
			status_d = empty ? spq_pkg::ST_EMPTY : spq_pkg::ST_REMOVED;
		end else begin
			status_d = full ? spq_pkg::ST_FULL : spq_pkg::ST_INSERTED;
		end
	end

	for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
		logic                     left_keep;
		logic [VB-1:0]            left_value;
		logic [PRIORITY_BITS-1:0] left_prio;
		logic [VB-1:0]            right_value;
		logic [PRIORITY_BITS-1:0] right_prio;

		if (k == 0) begin : g_head
			assign left_keep  = 1'b1;
			assign left_value = in_value;
			assign left_prio  = in_prio;
		end else begin : g_body
			assign left_keep  = cell_keep[k-1];
			assign left_value = cell_value[k-1];
			assign left_prio  = cell_prio[k-1];
		end

		if (k == QUEUE_DEPTH - 1) begin : g_tail
			assign right_value = cell_value[k];
			assign right_prio  = cell_prio[k];
		end else begin : g_inner
			assign right_value = cell_value[k+1];
			assign right_prio  = cell_prio[k+1];
		end

		spq_cell #(
			.PRIO_BITS(PRIORITY_BITS)
		) u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.occupied   (CW'(k) < count_q),
			.new_value  (in_value),
			.new_prio   (in_prio),
			.left_keep  (left_keep),
			.left_value (left_value),
			.left_prio  (left_prio),
			.right_value(right_value),
			.right_prio (right_prio),
			.value      (cell_value[k]),
			.prio       (cell_prio[k]),
			.keep       (cell_keep[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.ins) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.rem) begin
				count_q <= count_q - CW'(1);
			end
			if (in_fire) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			out_status_q <= status_d;
			if (cmd.rem) begin
				out_value_q <= cell_value[0];
				out_prio_q  <= opri_ext[RB-1:0];
			end else begin
				out_value_q <= '0;
				out_prio_q  <= '0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_prio_q, out_value_q};
	assign m_axis_tuser  = out_status_q;

	`include "assert_macros.svh"

	`SPQ_ASSERT(a_count_bound, clk, arst_n, count_q <= CW'(QUEUE_DEPTH), "fill count past depth")
	`SPQ_ASSERT_IMPL(a_head_order, clk, arst_n, count_q >= CW'(2), cell_prio[0] >= cell_prio[1], "chain head out of order")
	`SPQ_ASSERT_IMPL(a_full_hold, clk, arst_n, in_fire && !is_remove && full, ##1 count_q == $past(count_q), "rejected insert changed count")

endmodule
